[hw/rtl/rpv_pkg.sv]
`default_nettype none
package rpv_pkg;

  localparam int HEADER_BYTES        = 64;
  localparam int RECORD_HEADER_BYTES = 8;
  localparam int LENGTH_BITS_DEFAULT = 32;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  localparam logic [7:0] MAGIC [8] = '{8'h43, 8'h56, 8'h49, 8'h54,
                                       8'h45, 8'h50, 8'h4b, 8'h47};

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_INVALID     = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_CHECKSUM    = 3'd4;

  localparam logic [1:0] FAULT_NONE        = 2'd0;
  localparam logic [1:0] FAULT_INVALID     = 2'd1;
  localparam logic [1:0] FAULT_UNSUPPORTED = 2'd2;

  localparam logic [7:0] REG_MAJOR    = 8'd0;
  localparam logic [7:0] REG_ALLOWED  = 8'd1;
  localparam logic [7:0] REG_CHECKSUM = 8'd2;
  localparam logic [7:0] REG_MANIFEST = 8'd3;
  localparam logic [7:0] REG_OBJECT   = 8'd4;
  localparam logic [7:0] REG_CRITICAL = 8'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] major_ver;
    logic [15:0] minor_ver;
    logic [15:0] header_flags;
    logic [63:0] base_gen;
    logic [63:0] cand_gen;
    logic [31:0] rec_count;
    logic [63:0] rec_region_size;
    logic [63:0] pay_region_size;
    logic [63:0] declared_checksum;
  } out_t;

  typedef struct packed {
    logic [15:0] expected_major_version;
    logic [15:0] allowed_flag_mask;
    logic [15:0] checksum_flag_mask;
    logic [15:0] manifest_record_type;
    logic [15:0] object_record_type;
    logic [15:0] critical_record_mask;
  } cfg_t;

  // packet summary handed to the status check
  typedef struct packed {
    logic        magic_ok;
    logic [63:0] hash;
    logic [1:0]  walk_fault;
    logic        walk_done;
  } sum_t;

  // hash * FNV prime, prime = 2^40 + 0x1b3
  function automatic logic [63:0] fnv_mul(input logic [63:0] h);
    fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/record_packet_validator.sv]
`default_nettype none
// Record packet validator. Takes one packet byte per transfer, last byte
// flagged, and gives one result transfer per packet carrying the status and
// the decoded 64-byte header. A byte is taken every cycle while in_ready is
// high: header bytes are stored, each later byte costs one hash update
// (shift-add by the FNV prime) and one step of the record walk in the byte
// stage; end-of-packet checks run one stage later into the output register.
// Input stalls only when a finished result and the one behind it both wait.
// Configuration writes (index 0..5, others ignored) are always taken.
module record_packet_validator #(
  parameter int LENGTH_BITS = rpv_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rpv_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rpv_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);
  import rpv_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LIM = '1;

  cfg_t cfg;

  logic [LENGTH_BITS-1:0] byte_counter, byte_counter_next;
  logic                   magic_ok, magic_ok_next;
  logic [63:0]            held_header [8];
  logic [63:0]            held_header_next [8];
  logic [63:0]            hash_acc, hash_acc_next;
  logic [63:0]            region_left, region_left_next;
  logic [31:0]            records_left, records_left_next;
  logic [2:0]             rec_header_pos, rec_header_pos_next;
  logic [31:0]            rec_type_flags, rec_type_flags_next;
  logic [31:0]            rec_size, rec_size_next;
  logic [31:0]            rec_bytes_left, rec_bytes_left_next;
  logic [1:0]             walk_fault, walk_fault_next;

  logic                   snap_valid;
  logic [LENGTH_BITS-1:0] snap_count;
  logic [63:0]            snap_hdr [8];
  sum_t                   snap_sum;
  logic [2:0]             status;

  logic in_xfer, snap_move;
  logic [7:0]  b;
  logic [31:0] size_full, records_dec;
  logic [63:0] region_dec;
  logic        known;

  assign cfg_ready = 1'b1;
  assign snap_move = snap_valid && (!out_valid || out_ready);
  assign in_ready  = !snap_valid || !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign b         = in_data.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd1};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAJOR:    cfg.expected_major_version <= cfg_data;
        REG_ALLOWED:  cfg.allowed_flag_mask <= cfg_data;
        REG_CHECKSUM: cfg.checksum_flag_mask <= cfg_data;
        REG_MANIFEST: cfg.manifest_record_type <= cfg_data;
        REG_OBJECT:   cfg.object_record_type <= cfg_data;
        REG_CRITICAL: cfg.critical_record_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  assign size_full   = rec_size | {b, 24'd0};
  assign records_dec = records_left - 32'd1;
  assign region_dec  = region_left - {32'd0, size_full};
  assign known = rec_type_flags[15:0] == cfg.manifest_record_type ||
                 rec_type_flags[15:0] == cfg.object_record_type;

  always_comb begin
    byte_counter_next   = (byte_counter == LIM) ? byte_counter : byte_counter + 1'b1;
    magic_ok_next       = magic_ok;
    held_header_next    = held_header;
    hash_acc_next       = hash_acc;
    region_left_next    = region_left;
    records_left_next   = records_left;
    rec_header_pos_next = rec_header_pos;
    rec_type_flags_next = rec_type_flags;
    rec_size_next       = rec_size;
    rec_bytes_left_next = rec_bytes_left;
    walk_fault_next     = walk_fault;
    if (byte_counter < LENGTH_BITS'(HEADER_BYTES)) begin
      if (byte_counter < LENGTH_BITS'(8) && b != MAGIC[byte_counter[2:0]])
        magic_ok_next = 1'b0;
      for (int k = 0; k < 8; k++) begin
        if (byte_counter[2:0] == 3'(k))
          held_header_next[byte_counter[5:3]][k*8 +: 8] = b;
      end
      if (byte_counter == LENGTH_BITS'(HEADER_BYTES - 1)) begin
        region_left_next    = held_header_next[5];
        records_left_next   = held_header_next[4][31:0];
        rec_header_pos_next = 3'd0;
        rec_type_flags_next = 32'd0;
        rec_size_next       = 32'd0;
        rec_bytes_left_next = 32'd0;
        walk_fault_next = (held_header_next[4][31:0] != 32'd0 &&
                           held_header_next[5] < 64'(RECORD_HEADER_BYTES)) ?
                          FAULT_INVALID : FAULT_NONE;
      end
    end else begin
      hash_acc_next = fnv_mul(hash_acc ^ {56'd0, b});
      if (walk_fault == FAULT_NONE) begin
        if (rec_bytes_left != 32'd0) begin
          rec_bytes_left_next = rec_bytes_left - 32'd1;
        end else if (records_left != 32'd0) begin
          for (int k = 0; k < 4; k++) begin
            if (rec_header_pos == 3'(k)) rec_type_flags_next[k*8 +: 8] = b;
            if (rec_header_pos == 3'(k + 4)) rec_size_next[k*8 +: 8] = b;
          end
          if (rec_header_pos == 3'(RECORD_HEADER_BYTES - 1)) begin
            if (size_full < 32'(RECORD_HEADER_BYTES) || size_full[2:0] != 3'd0 ||
                {32'd0, size_full} > region_left) begin
              walk_fault_next = FAULT_INVALID;
            end else if (!known &&
                         (rec_type_flags[31:16] & cfg.critical_record_mask) != 16'd0) begin
              walk_fault_next = FAULT_UNSUPPORTED;
            end else begin
              records_left_next   = records_dec;
              region_left_next    = region_dec;
              rec_bytes_left_next = size_full - 32'(RECORD_HEADER_BYTES);
              if (records_dec != 32'd0 && region_dec < 64'(RECORD_HEADER_BYTES))
                walk_fault_next = FAULT_INVALID;
            end
            rec_header_pos_next = 3'd0;
            rec_type_flags_next = 32'd0;
            rec_size_next       = 32'd0;
          end else begin
            rec_header_pos_next = rec_header_pos + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_xfer && in_data.last_byte)) begin
      byte_counter   <= '0;
      magic_ok       <= 1'b1;
      held_header    <= '{default: 64'd0};
      hash_acc       <= FNV_BASIS;
      region_left    <= 64'd0;
      records_left   <= 32'd0;
      rec_header_pos <= 3'd0;
      rec_type_flags <= 32'd0;
      rec_size       <= 32'd0;
      rec_bytes_left <= 32'd0;
      walk_fault     <= FAULT_NONE;
    end else if (in_xfer) begin
      byte_counter   <= byte_counter_next;
      magic_ok       <= magic_ok_next;
      held_header    <= held_header_next;
      hash_acc       <= hash_acc_next;
      region_left    <= region_left_next;
      records_left   <= records_left_next;
      rec_header_pos <= rec_header_pos_next;
      rec_type_flags <= rec_type_flags_next;
      rec_size       <= rec_size_next;
      rec_bytes_left <= rec_bytes_left_next;
      walk_fault     <= walk_fault_next;
    end
  end

  // end-of-packet snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_xfer && in_data.last_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
    if (in_xfer && in_data.last_byte) begin
      snap_count             <= byte_counter_next;
      snap_hdr               <= held_header_next;
      snap_sum.magic_ok      <= magic_ok_next;
      snap_sum.hash          <= hash_acc_next;
      snap_sum.walk_fault    <= walk_fault_next;
      snap_sum.walk_done     <= records_left_next == 32'd0 && region_left_next == 64'd0;
    end
  end

  rpv_status #(.LENGTH_BITS(LENGTH_BITS)) u_status (
    .count  (snap_count),
    .hdr    (snap_hdr),
    .summ   (snap_sum),
    .cfg    (cfg),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (snap_move) begin
      out_data.status            <= status;
      out_data.major_ver         <= snap_hdr[1][15:0];
      out_data.minor_ver         <= snap_hdr[1][31:16];
      out_data.header_flags      <= snap_hdr[1][63:48];
      out_data.base_gen          <= snap_hdr[2];
      out_data.cand_gen          <= snap_hdr[3];
      out_data.rec_count         <= snap_hdr[4][31:0];
      out_data.rec_region_size   <= snap_hdr[5];
      out_data.pay_region_size   <= snap_hdr[6];
      out_data.declared_checksum <= snap_hdr[7];
    end
  end

  a_stall: assert property (@(posedge clk) disable iff (rst)
    snap_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both result stages are full");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_data.last_byte |=> byte_counter == '0 && walk_fault == FAULT_NONE)
    else $error("packet state not cleared after last byte");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_CHECKSUM)
    else $error("status code out of range");

  a_fault: assert property (@(posedge clk) disable iff (rst)
    walk_fault != 2'd3)
    else $error("walk fault code out of range");

endmodule
`default_nettype wire

[hw/rtl/rpv_status.sv]
`default_nettype none
module rpv_status #(
  parameter int LENGTH_BITS = rpv_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic [LENGTH_BITS-1:0] count,
  input  wire logic [63:0]            hdr [8],
  input  wire rpv_pkg::sum_t          summ,
  input  wire rpv_pkg::cfg_t          cfg,
  output logic [2:0]                  status
);
  import rpv_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LIM = '1;

  logic [15:0] major, hsize, flags;
  logic [65:0] total, count_ext;
  logic        length_bad;

  assign major     = hdr[1][15:0];
  assign hsize     = hdr[1][47:32];
  assign flags     = hdr[1][63:48];
  assign total     = {2'b00, hdr[5]} + {2'b00, hdr[6]} + 66'(HEADER_BYTES);
  assign count_ext = {{(66-LENGTH_BITS){1'b0}}, count};
  assign length_bad = (count == LIM) || (total != count_ext);

  always_comb begin
    if (count < LENGTH_BITS'(HEADER_BYTES)) status = ST_SHORT;
    else if (!summ.magic_ok || hsize != 16'(HEADER_BYTES)) status = ST_INVALID;
    else if (major != cfg.expected_major_version) status = ST_UNSUPPORTED;
    else if ((flags & ~cfg.allowed_flag_mask) != 16'd0) status = ST_UNSUPPORTED;
    else if (hdr[3] <= hdr[2]) status = ST_INVALID;
    else if (length_bad) status = ST_INVALID;
    else if ((flags & cfg.checksum_flag_mask) != 16'd0 && summ.hash != hdr[7])
      status = ST_CHECKSUM;
    else if (summ.walk_fault == FAULT_INVALID) status = ST_INVALID;
    else if (summ.walk_fault == FAULT_UNSUPPORTED) status = ST_UNSUPPORTED;
    else if (!summ.walk_done) status = ST_INVALID;
    else status = ST_OK;
  end

endmodule
`default_nettype wire
